>>> rtl/pressure_temperature_compensation_assert.svh
// Assertion macros shared by the compensation block.
// Each expects signals named clk and rst in the module that uses it.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_ASSERT_SVH

// Same-cycle implication.
`define PCOMP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PCOMP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/pcomp_pkg.sv
`default_nettype none
package pcomp_pkg;

  // Register file geometry.
  localparam int unsigned NumRegs   = 4;
  localparam int unsigned RegWidth  = 48;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned AddrWidth = 5;

  // Field widths.
  localparam int unsigned AdcWidth   = 20;
  localparam int unsigned TempWidth  = 27;
  localparam int unsigned PressWidth = 32;
  localparam int unsigned CoefWidth  = 16;

  // Register indexes.
  localparam logic [1:0] RegTemp      = 2'd0;
  localparam logic [1:0] RegPressLow  = 2'd1;
  localparam logic [1:0] RegPressMid  = 2'd2;
  localparam logic [1:0] RegPressHigh = 2'd3;

  // Sample kinds.
  localparam logic KindTemp  = 1'b0;
  localparam logic KindPress = 1'b1;

  // Calibration words split out of the registers.
  typedef struct packed {
    logic [CoefWidth-1:0] t1;
    logic [CoefWidth-1:0] t2;
    logic [CoefWidth-1:0] t3;
    logic [CoefWidth-1:0] p1;
    logic [CoefWidth-1:0] p2;
    logic [CoefWidth-1:0] p3;
    logic [CoefWidth-1:0] p4;
    logic [CoefWidth-1:0] p5;
    logic [CoefWidth-1:0] p6;
    logic [CoefWidth-1:0] p7;
    logic [CoefWidth-1:0] p8;
    logic [CoefWidth-1:0] p9;
  } coef_t;

  // Controller states; each step state also names the datapath step.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T0, ST_T1, ST_T2, ST_T3,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5,
    ST_P6, ST_P7, ST_P8, ST_P9, ST_P10, ST_P11
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic   load_in;
    logic   exec;
    state_t step;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
    logic out_stall;
    logic v1_zero;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/pcomp_in_if.sv
`default_nettype none
interface pcomp_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic [pcomp_pkg::AdcWidth-1:0]  adc_sample;

  modport source (output valid, output action, output adc_sample, input ready);
  modport sink   (input valid, input action, input adc_sample, output ready);
endinterface
`default_nettype wire

>>> rtl/pcomp_out_if.sv
`default_nettype none
interface pcomp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   sample_kind;
  logic signed [pcomp_pkg::TempWidth-1:0] temperature_centi;
  logic [pcomp_pkg::PressWidth-1:0]       pressure_q24_8;
  logic                                   divisor_zero;

  modport source (output valid, output sample_kind, output temperature_centi,
                  output pressure_q24_8, output divisor_zero, input ready);
  modport sink   (input valid, input sample_kind, input temperature_centi,
                  input pressure_q24_8, input divisor_zero, output ready);
endinterface
`default_nettype wire

>>> rtl/pcomp_regs.sv
`default_nettype none
module pcomp_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pcomp_pkg::AddrWidth-1:0]    paddr,
  input  wire logic [pcomp_pkg::DataWidth-1:0]    pwdata,
  output      logic [pcomp_pkg::DataWidth-1:0]    prdata,
  output      pcomp_pkg::coef_t                   coef
);

  logic [pcomp_pkg::RegWidth-1:0] regs [pcomp_pkg::NumRegs];
  logic [1:0]                     idx;

  // Registers sit on 8-byte boundaries.
  assign idx = paddr[4:3];

  // Write at the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pcomp_pkg::NumRegs; i++) begin
        regs[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      regs[idx] <= pwdata[pcomp_pkg::RegWidth-1:0];
    end
  end

  // Read back, upper bits zero.
  assign prdata = {{(pcomp_pkg::DataWidth-pcomp_pkg::RegWidth){1'b0}}, regs[idx]};

  // Unpack the calibration words.
  assign coef.t1 = regs[pcomp_pkg::RegTemp][15:0];
  assign coef.t2 = regs[pcomp_pkg::RegTemp][31:16];
  assign coef.t3 = regs[pcomp_pkg::RegTemp][47:32];
  assign coef.p1 = regs[pcomp_pkg::RegPressLow][15:0];
  assign coef.p2 = regs[pcomp_pkg::RegPressLow][31:16];
  assign coef.p3 = regs[pcomp_pkg::RegPressLow][47:32];
  assign coef.p4 = regs[pcomp_pkg::RegPressMid][15:0];
  assign coef.p5 = regs[pcomp_pkg::RegPressMid][31:16];
  assign coef.p6 = regs[pcomp_pkg::RegPressMid][47:32];
  assign coef.p7 = regs[pcomp_pkg::RegPressHigh][15:0];
  assign coef.p8 = regs[pcomp_pkg::RegPressHigh][31:16];
  assign coef.p9 = regs[pcomp_pkg::RegPressHigh][47:32];

endmodule
`default_nettype wire

>>> rtl/pcomp_dp.sv
`default_nettype none
module pcomp_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire pcomp_pkg::cmd_t                        cmd,
  output      pcomp_pkg::status_t                     status,
  input  wire pcomp_pkg::coef_t                       coef,
  input  wire logic                                   in_action,
  input  wire logic [pcomp_pkg::AdcWidth-1:0]         in_adc,
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic                                   out_kind,
  output      logic signed [pcomp_pkg::TempWidth-1:0] out_temp,
  output      logic [pcomp_pkg::PressWidth-1:0]       out_press,
  output      logic                                   out_zero
);

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] v, input int unsigned s);
    return 64'($signed(v) >>> s);
  endfunction

  // Item registers and working registers.
  logic                              kind;
  logic [pcomp_pkg::AdcWidth-1:0]    adc;
  logic [31:0]                       fine_temp, fine_temp_next;
  logic [63:0]                       ra, rb, rc, rd;
  logic [63:0]                       ra_next, rb_next, rc_next, rd_next;
  logic [63:0]                       adc64, t1u, p1u, tf, tval, psum;

  // Multiplier: 64x64 low product, 16 bits of b per cycle.
  logic        mbusy;
  logic [1:0]  mcnt;
  logic [63:0] ma, mb, macc;
  logic        mul_go;
  logic [63:0] mul_a, mul_b;

  // Divider: restoring, one quotient bit per cycle.
  logic        dbusy, dneg;
  logic [5:0]  dcnt;
  logic [63:0] drem, dquo, dd;
  logic [64:0] dshift;
  logic        div_go;
  logic [63:0] qo;

  // Output stage.
  logic                              load_out, lo_kind, lo_zero;
  logic signed [pcomp_pkg::TempWidth-1:0] lo_temp;
  logic [pcomp_pkg::PressWidth-1:0]  lo_press;

  assign adc64 = {44'b0, adc};
  assign t1u   = {48'b0, coef.t1};
  assign p1u   = {48'b0, coef.p1};
  assign qo    = dneg ? (64'd0 - dquo) : dquo;

  assign status.busy      = mbusy | dbusy;
  assign status.out_stall = out_valid & ~out_ready;
  assign status.v1_zero   = (macc[63:33] == '0);

  // Step decode: operands, register updates and results.
  always_comb begin
    mul_go = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_go = 1'b0;
    load_out = 1'b0;
    lo_kind = pcomp_pkg::KindTemp;
    lo_temp = '0;
    lo_press = '0;
    lo_zero = 1'b0;
    ra_next = ra;
    rb_next = rb;
    rc_next = rc;
    rd_next = rd;
    fine_temp_next = fine_temp;
    tf = sx32(ra + asr(sx32(macc), 14));
    tval = asr(sx32((tf << 2) + tf + 64'd128), 8);
    psum = asr(rb + rd + asr(macc, 19), 8) + (sx16(coef.p7) << 4);
    if (cmd.exec) begin
      case (cmd.step)
        pcomp_pkg::ST_T0: begin
          mul_go = 1'b1;
          mul_a = sx32((adc64 >> 3) - (t1u << 1));
          mul_b = sx16(coef.t2);
        end
        pcomp_pkg::ST_T1: begin
          ra_next = asr(sx32(macc), 11);
          mul_go = 1'b1;
          mul_a = sx32((adc64 >> 4) - t1u);
          mul_b = sx32((adc64 >> 4) - t1u);
        end
        pcomp_pkg::ST_T2: begin
          mul_go = 1'b1;
          mul_a = asr(sx32(macc), 12);
          mul_b = sx16(coef.t3);
        end
        pcomp_pkg::ST_T3: begin
          fine_temp_next = tf[31:0];
          load_out = 1'b1;
          lo_kind = kind;
          lo_temp = tval[pcomp_pkg::TempWidth-1:0];
        end
        pcomp_pkg::ST_P0: begin
          ra_next = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
          mul_go = 1'b1;
          mul_a = ra_next;
          mul_b = ra_next;
        end
        pcomp_pkg::ST_P1: begin
          rb_next = macc;
          mul_go = 1'b1;
          mul_a = macc;
          mul_b = sx16(coef.p6);
        end
        pcomp_pkg::ST_P2: begin
          rc_next = macc;
          mul_go = 1'b1;
          mul_a = ra;
          mul_b = sx16(coef.p5);
        end
        pcomp_pkg::ST_P3: begin
          rc_next = rc + (macc << 17) + (sx16(coef.p4) << 35);
          mul_go = 1'b1;
          mul_a = rb;
          mul_b = sx16(coef.p3);
        end
        pcomp_pkg::ST_P4: begin
          rd_next = asr(macc, 8);
          mul_go = 1'b1;
          mul_a = ra;
          mul_b = sx16(coef.p2);
        end
        pcomp_pkg::ST_P5: begin
          mul_go = 1'b1;
          mul_a = rd + (macc << 12) + (64'd1 << 47);
          mul_b = p1u;
        end
        pcomp_pkg::ST_P6: begin
          ra_next = asr(macc, 33);
          if (status.v1_zero) begin
            load_out = 1'b1;
            lo_kind = kind;
            lo_zero = 1'b1;
          end else begin
            mul_go = 1'b1;
            mul_a = ((64'd1048576 - adc64) << 31) - rc;
            mul_b = 64'd3125;
          end
        end
        pcomp_pkg::ST_P7: begin
          div_go = 1'b1;
        end
        pcomp_pkg::ST_P8: begin
          rb_next = qo;
          rc_next = asr(qo, 13);
          mul_go = 1'b1;
          mul_a = sx16(coef.p9);
          mul_b = asr(qo, 13);
        end
        pcomp_pkg::ST_P9: begin
          mul_go = 1'b1;
          mul_a = macc;
          mul_b = rc;
        end
        pcomp_pkg::ST_P10: begin
          rd_next = asr(macc, 25);
          mul_go = 1'b1;
          mul_a = sx16(coef.p8);
          mul_b = rb;
        end
        pcomp_pkg::ST_P11: begin
          load_out = 1'b1;
          lo_kind = kind;
          lo_press = psum[pcomp_pkg::PressWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Item capture, working registers and fine temperature.
  always_ff @(posedge clk) begin
    if (rst) begin
      fine_temp <= '0;
    end else begin
      fine_temp <= fine_temp_next;
    end
    if (cmd.load_in) begin
      kind <= in_action;
      adc  <= in_adc;
    end
    ra <= ra_next;
    rb <= rb_next;
    rc <= rc_next;
    rd <= rd_next;
  end

  // Shared multiplier.
  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
    end else if (mul_go) begin
      mbusy <= 1'b1;
    end else if (mbusy && mcnt == 2'd3) begin
      mbusy <= 1'b0;
    end
    if (mul_go) begin
      ma   <= mul_a;
      mb   <= mul_b;
      macc <= '0;
      mcnt <= '0;
    end else if (mbusy) begin
      macc <= macc + ma * {48'b0, mb[15:0]};
      ma   <= ma << 16;
      mb   <= mb >> 16;
      mcnt <= mcnt + 2'd1;
    end
  end

  // Divider on magnitudes; sign applied when the quotient is read.
  assign dshift = {drem, dquo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
    end else if (div_go) begin
      dbusy <= 1'b1;
    end else if (dbusy && dcnt == 6'd63) begin
      dbusy <= 1'b0;
    end
    if (div_go) begin
      dneg <= macc[63] ^ ra[63];
      dquo <= macc[63] ? (64'd0 - macc) : macc;
      dd   <= ra[63] ? (64'd0 - ra) : ra;
      drem <= '0;
      dcnt <= '0;
    end else if (dbusy) begin
      if (dshift >= {1'b0, dd}) begin
        drem <= 64'(dshift - {1'b0, dd});
        dquo <= {dquo[62:0], 1'b1};
      end else begin
        drem <= dshift[63:0];
        dquo <= {dquo[62:0], 1'b0};
      end
      dcnt <= dcnt + 6'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      out_kind  <= lo_kind;
      out_temp  <= lo_temp;
      out_press <= lo_press;
      out_zero  <= lo_zero;
    end
  end

endmodule
`default_nettype wire

>>> rtl/pcomp_ctrl.sv
`default_nettype none
`include "pressure_temperature_compensation_assert.svh"
module pcomp_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_action,
  output      logic               in_ready,
  input  wire pcomp_pkg::status_t status,
  output      pcomp_pkg::cmd_t    cmd
);

  pcomp_pkg::state_t state, state_next;
  logic              accept;

  assign accept = in_valid & in_ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcomp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the steps; a step runs once the shared units are free and the output is not stalled.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    cmd.step    = state;
    case (state)
      pcomp_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_next = (in_action == pcomp_pkg::KindPress) ? pcomp_pkg::ST_P0
                                                           : pcomp_pkg::ST_T0;
        end
      end
      default: begin
        if (!status.busy && !status.out_stall) begin
          cmd.exec = 1'b1;
          case (state)
            pcomp_pkg::ST_T0:  state_next = pcomp_pkg::ST_T1;
            pcomp_pkg::ST_T1:  state_next = pcomp_pkg::ST_T2;
            pcomp_pkg::ST_T2:  state_next = pcomp_pkg::ST_T3;
            pcomp_pkg::ST_P0:  state_next = pcomp_pkg::ST_P1;
            pcomp_pkg::ST_P1:  state_next = pcomp_pkg::ST_P2;
            pcomp_pkg::ST_P2:  state_next = pcomp_pkg::ST_P3;
            pcomp_pkg::ST_P3:  state_next = pcomp_pkg::ST_P4;
            pcomp_pkg::ST_P4:  state_next = pcomp_pkg::ST_P5;
            pcomp_pkg::ST_P5:  state_next = pcomp_pkg::ST_P6;
            pcomp_pkg::ST_P6:  state_next = status.v1_zero ? pcomp_pkg::ST_IDLE
                                                           : pcomp_pkg::ST_P7;
            pcomp_pkg::ST_P7:  state_next = pcomp_pkg::ST_P8;
            pcomp_pkg::ST_P8:  state_next = pcomp_pkg::ST_P9;
            pcomp_pkg::ST_P9:  state_next = pcomp_pkg::ST_P10;
            pcomp_pkg::ST_P10: state_next = pcomp_pkg::ST_P11;
            default:           state_next = pcomp_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  // The shared units are never left running between items.
  `PCOMP_ASSERT_IMP(a_idle_units_free, state == pcomp_pkg::ST_IDLE, !status.busy, "unit busy in idle")
  // An accepted word always starts a step sequence.
  `PCOMP_ASSERT_NXT(a_accept_starts, accept, state != pcomp_pkg::ST_IDLE, "accept did not start")
  // The sequence holds while a unit is still working.
  `PCOMP_ASSERT_NXT(a_hold_on_busy, status.busy && state != pcomp_pkg::ST_IDLE, state == $past(state), "advanced while busy")

endmodule
`default_nettype wire

>>> rtl/pressure_temperature_compensation.sv
// Barometric temperature and pressure compensation.
// Input channel "sample" carries one word per raw converter reading: action
// selects temperature (0) or pressure (1) and adc_sample holds the 20-bit code.
// Output channel "result" returns one word per input word with the echoed kind,
// the temperature in hundredths of a degree or the pressure in Q24.8 pascals,
// and a flag set when the pressure divisor was zero.
// Calibration is written over the APB port, one 48-bit register every 8 bytes;
// write it only while the block is idle.
// One item is in work at a time. A temperature word runs its steps on the
// shared multiplier; a pressure word also uses the restoring divider, unless
// the divisor is zero.
// A new word can be accepted in the cycle after the previous result is
// loaded. While the receiver holds back a result, the steps of the next word
// wait until that result is taken.
// Reset clears the calibration registers, the stored fine temperature and the
// output valid.
`default_nettype none
module pressure_temperature_compensation (
  input  wire logic                            clk,
  input  wire logic                            rst,
  pcomp_in_if.sink                             sample,
  pcomp_out_if.source                          result,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [pcomp_pkg::AddrWidth-1:0] paddr,
  input  wire logic [pcomp_pkg::DataWidth-1:0] pwdata,
  output      logic [pcomp_pkg::DataWidth-1:0] prdata,
  output      logic                            pready
);

  pcomp_pkg::coef_t   coef;
  pcomp_pkg::cmd_t    cmd;
  pcomp_pkg::status_t status;
  logic               in_ready;

  assign pready       = 1'b1;
  assign sample.ready = in_ready;

  // Calibration registers.
  pcomp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .coef    (coef)
  );

  // Step sequencer.
  pcomp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_action (sample.action),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and result register.
  pcomp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .coef      (coef),
    .in_action (sample.action),
    .in_adc    (sample.adc_sample),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_kind  (result.sample_kind),
    .out_temp  (result.temperature_centi),
    .out_press (result.pressure_q24_8),
    .out_zero  (result.divisor_zero)
  );

endmodule
`default_nettype wire
